// File: hdl/lscr_pkg.sv
// ----------------------------------------------------------------------------
// lscr_pkg
// Shared widths and request types of the 3x3 Cramer's rule linear solver.
// ----------------------------------------------------------------------------
`default_nettype none

package lscr_pkg;

    // fixed point format of every coefficient and solution word
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // 2x2 minor, exact
    localparam int MINOR_BITS = 2 * WORD_BITS + 1;
    // 3x3 determinant, exact, units of 2^-(3*FRAC_BITS)
    localparam int DET_BITS = 3 * WORD_BITS + 3;
    // singularity threshold register
    localparam int THR_BITS = 63;
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

    // one system to solve
    typedef struct packed {
        logic signed [WORD_BITS-1:0] coef_11;
        logic signed [WORD_BITS-1:0] coef_12;
        logic signed [WORD_BITS-1:0] coef_13;
        logic signed [WORD_BITS-1:0] coef_21;
        logic signed [WORD_BITS-1:0] coef_22;
        logic signed [WORD_BITS-1:0] coef_23;
        logic signed [WORD_BITS-1:0] coef_31;
        logic signed [WORD_BITS-1:0] coef_32;
        logic signed [WORD_BITS-1:0] coef_33;
        logic signed [WORD_BITS-1:0] rhs_1;
        logic signed [WORD_BITS-1:0] rhs_2;
        logic signed [WORD_BITS-1:0] rhs_3;
    } t_in_item;

    // one solution
    typedef struct packed {
        logic signed [WORD_BITS-1:0] sol_x;
        logic signed [WORD_BITS-1:0] sol_y;
        logic signed [WORD_BITS-1:0] sol_z;
        logic                        solved;
    } t_out_item;

endpackage

`default_nettype wire

// File: hdl/lscr_det.sv
// ----------------------------------------------------------------------------
// lscr_det
// Four-stage exact determinant pipeline: main determinant and the three
// determinants with one column replaced by the right-hand side.
// ----------------------------------------------------------------------------
`default_nettype none

module lscr_det (
    input  wire                                    i_clk,
    input  wire                                    i_en,
    input  wire lscr_pkg::t_in_item                i_item,
    output logic signed [lscr_pkg::DET_BITS-1:0]   o_det [4]
);

    localparam int W  = lscr_pkg::WORD_BITS;
    localparam int MW = lscr_pkg::MINOR_BITS;
    localparam int DW = lscr_pkg::DET_BITS;

    logic signed [W-1:0]    a [3][3];
    logic signed [W-1:0]    b [3];

    logic signed [2*W-1:0]  r_pa [3][3];
    logic signed [2*W-1:0]  r_pb [3][3];
    logic signed [MW-1:0]   r_m  [3][3];
    logic signed [W-1:0]    r_cf1 [4][3];
    logic signed [W-1:0]    r_cf2 [4][3];
    logic signed [2*W:0]    r_lo [4][3];
    logic signed [2*W:0]    r_hi [4][3];
    logic signed [DW-1:0]   n_det [4];

    // unpack the request
    always_comb begin
        a[0][0] = i_item.coef_11; a[0][1] = i_item.coef_12; a[0][2] = i_item.coef_13;
        a[1][0] = i_item.coef_21; a[1][1] = i_item.coef_22; a[1][2] = i_item.coef_23;
        a[2][0] = i_item.coef_31; a[2][1] = i_item.coef_32; a[2][2] = i_item.coef_33;
        b[0] = i_item.rhs_1;
        b[1] = i_item.rhs_2;
        b[2] = i_item.rhs_3;
    end

    // stages 1 and 2: products and differences of every 2x2 minor
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int R0 = (gi == 0) ? 1 : 0;
            localparam int R1 = (gi == 2) ? 1 : 2;
            localparam int C0 = (gj == 0) ? 1 : 0;
            localparam int C1 = (gj == 2) ? 1 : 2;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa[gi][gj] <= (2*W)'(a[R0][C0]) * (2*W)'(a[R1][C1]);
                    r_pb[gi][gj] <= (2*W)'(a[R0][C1]) * (2*W)'(a[R1][C0]);
                    r_m[gi][gj]  <= MW'(r_pa[gi][gj]) - MW'(r_pb[gi][gj]);
                end
            end
        end
    end

    // stage 3: coefficient times minor, minor split in two halves
    for (genvar gd = 0; gd < 4; gd++) begin : g_det
        localparam int C = (gd == 0) ? 0 : gd - 1;
        for (genvar gi = 0; gi < 3; gi++) begin : g_term
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_cf1[gd][gi] <= (gd == 0) ? a[gi][0] : b[gi];
                    r_cf2[gd][gi] <= r_cf1[gd][gi];
                    r_lo[gd][gi]  <= (2*W+1)'(r_cf2[gd][gi])
                                     * (2*W+1)'($signed({1'b0, r_m[gi][C][W-1:0]}));
                    r_hi[gd][gi]  <= (2*W+1)'(r_cf2[gd][gi])
                                     * (2*W+1)'($signed(r_m[gi][C][MW-1:W]));
                end
            end
        end
    end

    // stage 4: join halves and sum the signed cofactor terms
    always_comb begin
        logic signed [DW-1:0] term;
        int c;
        for (int d = 0; d < 4; d++) begin
            n_det[d] = '0;
            c = (d == 0) ? 0 : d - 1;
            for (int i = 0; i < 3; i++) begin
                term = (DW'(r_hi[d][i]) <<< W) + DW'(r_lo[d][i]);
                if (((i + c) % 2) == 0) begin
                    n_det[d] = n_det[d] + term;
                end else begin
                    n_det[d] = n_det[d] - term;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_det <= n_det;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lscr_div_lane.sv
// ----------------------------------------------------------------------------
// lscr_div_lane
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection, saturation, sign and zeroing of unsolved systems.
// ----------------------------------------------------------------------------
`default_nettype none

module lscr_div_lane (
    input  wire                                   i_clk,
    input  wire                                   i_en,
    input  wire  [lscr_pkg::DET_BITS-1:0]         i_num,
    input  wire  [lscr_pkg::DET_BITS-1:0]         i_den,
    input  wire                                   i_neg,
    input  wire                                   i_ok,
    output logic signed [lscr_pkg::WORD_BITS-1:0] o_res
);

    localparam int W  = lscr_pkg::WORD_BITS;
    localparam int F  = lscr_pkg::FRAC_BITS;
    localparam int DW = lscr_pkg::DET_BITS;
    localparam int RW = DW + F + W;
    localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

    logic [RW-1:0] r_rem [W];
    logic [RW-1:0] r_den [W];
    logic [W-2:0]  r_q   [W];
    logic          r_neg [W];
    logic          r_ok  [W];
    logic          r_ovf [W];
    logic [RW-1:0] n_rem0;

    // first stage: scale numerator, quotient overflow when it reaches 2^(W-1)
    assign n_rem0 = RW'(i_num) << F;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= RW'(i_den);
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ok[0]  <= i_ok;
            r_ovf[0] <= n_rem0 >= (RW'(i_den) << (W - 1));
        end
    end

    // one quotient bit per stage, msb first
    for (genvar gj = 1; gj < W; gj++) begin : g_bit
        localparam int K = W - 1 - gj;
        logic [RW-1:0] dsh;
        logic          fit;
        assign dsh = r_den[gj-1] << K;
        assign fit = r_rem[gj-1] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gj] <= fit ? (r_rem[gj-1] - dsh) : r_rem[gj-1];
                r_q[gj]   <= fit ? (r_q[gj-1] | ((W-1)'(1) << K)) : r_q[gj-1];
                r_den[gj] <= r_den[gj-1];
                r_neg[gj] <= r_neg[gj-1];
                r_ok[gj]  <= r_ok[gj-1];
                r_ovf[gj] <= r_ovf[gj-1];
            end
        end
    end

    // result register: zero, saturate or apply sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_ok[W-1]) begin
                o_res <= '0;
            end else if (r_ovf[W-1]) begin
                o_res <= r_neg[W-1] ? W_MIN : W_MAX;
            end else if (r_neg[W-1]) begin
                o_res <= W'(0) - W'(r_q[W-1]);
            end else begin
                o_res <= W'(r_q[W-1]);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/linear_solve_3x3_cramer.sv
// ----------------------------------------------------------------------------
// linear_solve_3x3_cramer
// Exact 3x3 linear solver by Cramer's rule, Q16.16 in and out, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------
//  input    | in        | i_valid / o_stall            | i_data (t_in_item)
//  output   | out       | o_valid / i_stall            | o_data (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_data (threshold)
//
//  one request accepted per cycle while the output is not stalled; stages:
//  4 determinant stages, 1 threshold stage, WORD_BITS+1 divider stages
//  the divider's one-bit-per-stage restoring loop sets the depth
//  synchronous active-low reset clears valid bits and sets the threshold to 1
//  a stall at the output freezes the whole pipeline; nothing is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module linear_solve_3x3_cramer (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  lscr_pkg::t_in_item        i_data,
    output logic                            o_valid,
    input  wire                             i_stall,
    output lscr_pkg::t_out_item             o_data,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [lscr_pkg::THR_BITS-1:0]   i_cfg_data
);

    localparam int W   = lscr_pkg::WORD_BITS;
    localparam int DW  = lscr_pkg::DET_BITS;
    localparam int LAT = W + 6;

    logic                      en;
    logic [LAT-1:0]            r_vld;
    logic [W:0]                r_okd;
    logic [lscr_pkg::THR_BITS-1:0] r_thr;
    logic signed [DW-1:0]      det [4];
    logic [DW-1:0]             n_abs [4];
    logic                      n_ok;
    logic [DW-1:0]             r_abs [4];
    logic                      r_neg [3];
    logic                      r_ok;
    logic signed [W-1:0]       res [3];

    // pipeline advances unless the output holds a stalled request
    assign en          = !o_valid || !i_stall;
    assign o_stall     = !en;
    assign o_valid     = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= lscr_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // valid bits and solved flag travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_okd <= {r_okd[W-1:0], r_ok};
        end
    end

    lscr_det u_det (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_data),
        .o_det  (det)
    );

    // magnitudes and singularity test
    always_comb begin
        n_ok = (det[0] != '0);
        for (int d = 0; d < 4; d++) begin
            n_abs[d] = det[d][DW-1] ? (DW'(0) - DW'(det[d])) : DW'(det[d]);
            if (n_abs[d] < DW'(r_thr)) begin
                n_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_abs <= n_abs;
            r_ok  <= n_ok;
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= det[k+1][DW-1] ^ det[0][DW-1];
            end
        end
    end

    // one divider lane per unknown
    for (genvar gk = 0; gk < 3; gk++) begin : g_lane
        lscr_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_abs[gk+1]),
            .i_den (r_abs[0]),
            .i_neg (r_neg[gk]),
            .i_ok  (r_ok),
            .o_res (res[gk])
        );
    end

    assign o_data.sol_x  = res[0];
    assign o_data.sol_y  = res[1];
    assign o_data.sol_z  = res[2];
    assign o_data.solved = r_okd[W];

    // unsolved systems carry zero solutions
    a_unsolved_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.solved) |->
        (o_data.sol_x == '0 && o_data.sol_y == '0 && o_data.sol_z == '0))
        else $error("unsolved system with nonzero solution");

    // input is held back only by a stalled result
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output stall");

    // reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("valid result right after reset");

endmodule

`default_nettype wire

// File: dv/lscr_solution_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_solution_checker
// Watches the request, solution and threshold channels of the 3x3 Cramer
// solver, predicts each solution exactly and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lscr_solution_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    input  wire                                i_in_stall,
    input  wire  lscr_pkg::t_in_item           i_in_data,
    input  wire                                i_out_valid,
    input  wire                                i_out_stall,
    input  wire  lscr_pkg::t_out_item          i_out_data,
    input  wire                                i_cfg_valid,
    input  wire                                i_cfg_ready,
    input  wire  [lscr_pkg::THR_BITS-1:0]      i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_solved_seen,
    output int                                 o_saturated_seen
);

    localparam int WB = lscr_pkg::WORD_BITS;
    localparam int FB = lscr_pkg::FRAC_BITS;
    localparam int TB = lscr_pkg::THR_BITS;

    typedef logic signed [127:0] t_wide;

    lscr_pkg::t_out_item solutions_due[$];
    logic [TB-1:0]       threshold;

    // exact 3x3 determinant, entries row major
    function automatic t_wide det3(t_wide m [9]);
        t_wide c1, c2, c3;
        c1 = m[4] * m[8] - m[7] * m[5];
        c2 = m[3] * m[8] - m[6] * m[5];
        c3 = m[3] * m[7] - m[6] * m[4];
        return m[0] * c1 - m[1] * c2 + m[2] * c3;
    endfunction

    // trunc(num * 2^FRAC_BITS / den), saturated to a signed word
    function automatic logic [WB-1:0] quotient(t_wide num, t_wide den);
        logic         neg;
        logic [127:0] n, d, q, lim;
        neg = num[127] ^ den[127];
        n   = num[127] ? -num : num;
        d   = den[127] ? -den : den;
        q   = (n << FB) / d;
        lim = (128'd1 << (WB - 1)) - (neg ? 128'd0 : 128'd1);
        if (q > lim) q = lim;
        return neg ? WB'(-q) : WB'(q);
    endfunction

    function automatic lscr_pkg::t_out_item solve_system(lscr_pkg::t_in_item s,
                                                         logic [TB-1:0] thr);
        t_wide               a [9];
        t_wide               b [3];
        t_wide               m [9];
        t_wide               dets [4];
        t_wide               mag;
        logic                ok;
        lscr_pkg::t_out_item r;
        a = '{t_wide'(s.coef_11), t_wide'(s.coef_12), t_wide'(s.coef_13),
              t_wide'(s.coef_21), t_wide'(s.coef_22), t_wide'(s.coef_23),
              t_wide'(s.coef_31), t_wide'(s.coef_32), t_wide'(s.coef_33)};
        b = '{t_wide'(s.rhs_1), t_wide'(s.rhs_2), t_wide'(s.rhs_3)};
        dets[0] = det3(a);
        for (int k = 0; k < 3; k++) begin
            m = a;
            for (int i = 0; i < 3; i++) m[i*3+k] = b[i];
            dets[k+1] = det3(m);
        end
        ok = (dets[0] != 0);
        for (int k = 0; k < 4; k++) begin
            mag = dets[k][127] ? -dets[k] : dets[k];
            if ($unsigned(mag) < {65'd0, thr}) ok = 1'b0;
        end
        r.solved = ok;
        r.sol_x  = ok ? quotient(dets[1], dets[0]) : '0;
        r.sol_y  = ok ? quotient(dets[2], dets[0]) : '0;
        r.sol_z  = ok ? quotient(dets[3], dets[0]) : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WB-1:0] got,
                                   logic [WB-1:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic is_rail(logic [WB-1:0] v);
        return v == {1'b0, {(WB-1){1'b1}}} || v == {1'b1, {(WB-1){1'b0}}};
    endfunction

    always @(posedge i_clk) begin
        lscr_pkg::t_out_item want;
        if (!i_rst_n) begin
            threshold        <= lscr_pkg::THR_RESET;
            o_fail_count     <= 0;
            o_pending        <= 0;
            o_checked        <= 0;
            o_solved_seen    <= 0;
            o_saturated_seen <= 0;
            solutions_due.delete();
        end else begin
            // threshold write
            if (i_cfg_valid && i_cfg_ready) threshold <= i_cfg_data;
            // accepted request
            if (i_in_valid && !i_in_stall)
                solutions_due.push_back(solve_system(i_in_data, threshold));
            // accepted solution
            if (i_out_valid && !i_out_stall) begin
                if (solutions_due.size() == 0) begin
                    $display("%0t solution with none expected", $realtime);
                    o_fail_count++;
                end else begin
                    want = solutions_due.pop_front();
                    o_checked++;
                    if (want.solved) o_solved_seen++;
                    if (want.solved && (is_rail(want.sol_x) || is_rail(want.sol_y)
                        || is_rail(want.sol_z))) o_saturated_seen++;
                    if (i_out_data.solved !== want.solved)
                        report_mismatch("solved", WB'(i_out_data.solved),
                                        WB'(want.solved));
                    if (i_out_data.sol_x !== want.sol_x)
                        report_mismatch("sol_x", i_out_data.sol_x, want.sol_x);
                    if (i_out_data.sol_y !== want.sol_y)
                        report_mismatch("sol_y", i_out_data.sol_y, want.sol_y);
                    if (i_out_data.sol_z !== want.sol_z)
                        report_mismatch("sol_z", i_out_data.sol_z, want.sol_z);
                end
            end
            // requests still in flight
            o_pending <= solutions_due.size();
        end
    end

endmodule

`default_nettype wire

// File: dv/linear_solve_3x3_cramer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_solve_3x3_cramer_tb
// Drives directed and random 3x3 systems through the solver under random
// gaps and stalls, sweeps the singularity threshold, and lets the checker
// compare every solution against an exact prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_solve_3x3_cramer_tb;

    localparam int ONE        = 32'h0001_0000;
    localparam int DRAIN_WAIT = 60;
    localparam int STALL_LIMIT = 5000;
    localparam int TB         = lscr_pkg::THR_BITS;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    lscr_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    lscr_pkg::t_out_item o_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TB-1:0]       i_cfg_data;

    int fail_count, pending, checked, solved_seen, saturated_seen;
    int idle_cycles;
    bit calm;
    bit hold_long;

    linear_solve_3x3_cramer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    lscr_solution_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_data        (i_data),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_data       (o_data),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_solved_seen    (solved_seen),
        .o_saturated_seen (saturated_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // known values from time zero
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        hold_long   = 1'b0;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d solutions outstanding", pending);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // solution receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_long = 1'b0;
            end
            n = calm ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic send_system(lscr_pkg::t_in_item s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [TB-1:0] thr);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic lscr_pkg::t_in_item make_system(int a11, int a12, int a13, int a21,
                                                       int a22, int a23, int a31, int a32,
                                                       int a33, int b1, int b2, int b3);
        return '{a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3};
    endfunction

    function automatic int small_word(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // random system: half well-conditioned, some degenerate, some raw noise
    function automatic lscr_pkg::t_in_item random_system();
        lscr_pkg::t_in_item s;
        int kind;
        kind = $urandom_range(0, 9);
        s.rhs_1 = small_word(64 * ONE);
        s.rhs_2 = small_word(64 * ONE);
        s.rhs_3 = small_word(64 * ONE);
        s.coef_11 = small_word(4 * ONE);
        s.coef_12 = small_word(4 * ONE);
        s.coef_13 = small_word(4 * ONE);
        s.coef_21 = small_word(4 * ONE);
        s.coef_22 = small_word(4 * ONE);
        s.coef_23 = small_word(4 * ONE);
        s.coef_31 = small_word(4 * ONE);
        s.coef_32 = small_word(4 * ONE);
        s.coef_33 = small_word(4 * ONE);
        if (kind < 5) begin
            // diagonally dominant
            s.coef_11 = s.coef_11 + ($urandom_range(0, 1) ? 16 * ONE : -16 * ONE);
            s.coef_22 = s.coef_22 + ($urandom_range(0, 1) ? 16 * ONE : -16 * ONE);
            s.coef_33 = s.coef_33 + ($urandom_range(0, 1) ? 16 * ONE : -16 * ONE);
        end else if (kind == 5) begin
            // third row dependent on the first two
            s.coef_31 = s.coef_11 + s.coef_21;
            s.coef_32 = s.coef_12 + s.coef_22;
            s.coef_33 = s.coef_13 + s.coef_23;
        end else if (kind == 6) begin
            // tiny diagonal, a12 and a21 entries, tiny determinants near the threshold
            s.coef_11 = small_word(300);
            s.coef_22 = small_word(300);
            s.coef_33 = small_word(300);
            s.coef_12 = small_word(3);
            s.coef_21 = small_word(3);
        end else begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        return s;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            send_system(random_system());
        end
        calm = 1'b0;
    endtask

    // stimulus
    initial begin
        int maxw, minw;
        maxw = 32'h7fff_ffff;
        minw = 32'h8000_0000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed systems at the reset threshold
        send_system(make_system(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, -2 * ONE, 3 * ONE));
        send_system(make_system(2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE,
                                5*ONE, -ONE, 7*ONE));
        send_system('0);
        send_system(make_system(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE));
        send_system(make_system(ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, ONE, 0, ONE,
                                ONE, ONE, ONE));
        send_system(make_system(1, 0, 0, 0, 1, 0, 0, 0, 1, maxw, minw, ONE));
        send_system(make_system(1, 0, 0, 0, 1, 0, 0, 0, 1, minw, maxw, -ONE));
        send_system(make_system(maxw, 0, 0, 0, maxw, 0, 0, 0, maxw, maxw, minw, 1));
        send_system(make_system(minw, 0, 0, 0, minw, 0, 0, 0, minw, minw, maxw, -1));
        send_system(make_system(minw, minw, minw, minw, maxw, minw, minw, minw, maxw,
                                minw, minw, maxw));
        send_system(make_system(maxw, minw, maxw, minw, maxw, minw, maxw, minw, minw,
                                maxw, maxw, minw));
        send_system(make_system(-1, 0, 0, 0, -1, 0, 0, 0, -1, -1, -1, -1));
        send_system(make_system(ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, -3*ONE, 3*ONE, -ONE));
        send_system({12{32'hffff_ffff}});
        send_system({12{32'h5555_5555}});
        send_system({12{32'haaaa_aaaa}});
        random_phase(600);

        // zero threshold: only an exactly zero main determinant fails
        write_threshold('0);
        send_system('0);
        send_system(make_system(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0));
        send_system(make_system(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, ONE));
        random_phase(350);

        // threshold at 1.0 in determinant units, with a long receiver hold-off
        write_threshold(TB'(64'd1 << 48));
        hold_long = 1'b1;
        random_phase(350);

        // largest threshold: only systems whose every determinant reaches 2^63-1 solve
        write_threshold({TB{1'b1}});
        send_system(make_system(maxw, 0, 0, 0, maxw, 0, 0, 0, maxw, maxw, maxw, maxw));
        random_phase(150);

        // random threshold, then back to one
        write_threshold(TB'($urandom) | (TB'($urandom) << 31));
        random_phase(150);
        write_threshold(TB'(1));
        random_phase(250);

        wait_drained();
        $display("checked %0d solutions: %0d solved, %0d with a saturated unknown",
                 checked, solved_seen, saturated_seen);
        $display("thresholds swept from zero to full scale, with gaps, stalls and backpressure");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
